FILE: hdl/stable_priority_queue_core_assert.svh
// Assertion macros for the stable priority queue core.
// Included by stable_priority_queue_core; no other dependencies.
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

FILE: hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue core.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam logic [31:0] ID_START_RESET = 32'd87970;
  localparam int unsigned OCC_W = 5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  priority_req;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [31:0]       entry_id;
    logic [63:0]       entry_payload;
    logic [7:0]        entry_priority;
    logic [31:0]       entry_stamp;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] id;
    logic [63:0] payload;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] prio;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/stable_priority_queue_core.sv
// Stable priority queue: one push or pop per cycle, result registered when the
// item is accepted. Every slot of the chain updates in the same cycle, so throughput
// is one item per cycle while the output register is not held by out_ready low.
// Reset clears the fill count, next stamp and output valid, and loads the next
// id with 87970; the entry slots are not cleared.
// Depends on spq_pkg, spq_cell and stable_priority_queue_core_assert.svh.
`default_nettype none

`include "stable_priority_queue_core_assert.svh"

module stable_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spq_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      next_id;
  logic [31:0]      next_stamp;

  logic               accept;
  logic               full;
  logic               empty;
  logic               do_push;
  logic               do_pop;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    new_entry;
  spq_pkg::entry_t    cells [DEPTH];
  logic               ins [DEPTH];
  spq_pkg::out_item_t result;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = accept && (in_data.func == spq_pkg::FUNC_PUSH) && !full;
  assign do_pop   = accept && (in_data.func == spq_pkg::FUNC_POP) && !empty;

  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;
  assign ctl.prio = in_data.priority_req;

  assign new_entry.prio    = in_data.priority_req;
  assign new_entry.id      = next_id;
  assign new_entry.payload = in_data.payload;
  assign new_entry.stamp   = next_stamp;

  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            prev_ins;
    if (i == 0) begin : g_head
      assign left_e   = '0;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign left_e   = cells[i-1];
      assign prev_ins = ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (CNT_W'(i) < count),
      .prev_ins  (prev_ins),
      .left      (left_e),
      .right     (right_e),
      .new_entry (new_entry),
      .ins       (ins[i]),
      .entry     (cells[i])
    );
  end

  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    result           = '0;
    result.occupancy = spq_pkg::OCC_W'(count_next);
    if (in_data.func == spq_pkg::FUNC_PUSH) begin
      if (full) begin
        result.status = spq_pkg::ST_FULL;
      end else begin
        result.status      = spq_pkg::ST_PUSHED;
        result.entry_id    = next_id;
        result.entry_stamp = next_stamp;
      end
    end else begin
      if (empty) begin
        result.status = spq_pkg::ST_EMPTY;
      end else begin
        result.status         = spq_pkg::ST_POPPED;
        result.entry_id       = cells[0].id;
        result.entry_payload  = cells[0].payload;
        result.entry_priority = cells[0].prio;
        result.entry_stamp    = cells[0].stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_id    <= spq_pkg::ID_START_RESET;
      next_stamp <= '0;
      out_valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (do_push) begin
        next_id    <= next_id + 32'd1;
        next_stamp <= next_stamp + 32'd1;
      end
      if (cfg_we) begin
        next_id <= cfg_wdata;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  `SPQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `SPQ_ASSERT_NOW(a_head_order, clk, rst, count >= CNT_W'(2), cells[0].prio <= cells[1].prio)
  `SPQ_ASSERT_NEXT(a_push_count, clk, rst, do_push, count == $past(count) + CNT_W'(1))
  `SPQ_ASSERT_NEXT(a_pop_stamp, clk, rst, do_pop, next_stamp == $past(next_stamp))

endmodule

`default_nettype wire

FILE: hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward tail on push
// past it, toward head on pop, or loads the new entry. Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic              clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire logic              occupied,
  input  wire logic              prev_ins,
  input  wire spq_pkg::entry_t   left,
  input  wire spq_pkg::entry_t   right,
  input  wire spq_pkg::entry_t   new_entry,
  output logic                   ins,
  output spq_pkg::entry_t        entry
);

  spq_pkg::entry_t held;

  // strictly greater keeps equal priorities in arrival order
  assign ins   = !occupied || (held.prio > ctl.prio);
  assign entry = held;

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      held <= right;
    end else if (ctl.push) begin
      if (ins && prev_ins) begin
        held <= left;
      end else if (ins) begin
        held <= new_entry;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for stable_priority_queue_core: a mirror of the sorted
// store predicts every result, which is checked against the block's output items.
// Depends on spq_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned LIMIT = 500000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_OPS = 100;
  localparam int unsigned CHUNK_OPS = 25;

  typedef enum int {MIX_BAL, MIX_FILL, MIX_DRAIN, MIX_TIES} mix_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  spq_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [31:0]        cfg_wdata = '0;

  stable_priority_queue_core #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the queue contents and counters
  spq_pkg::entry_t mirror_slots [DEPTH];
  int unsigned     mirror_fill;
  logic [31:0]     mirror_next_id;
  logic [31:0]     mirror_next_stamp;

  spq_pkg::in_item_t  pending_ops [$];
  spq_pkg::out_item_t predicted_results [$];
  int unsigned        ops_issued = 0;
  int unsigned        results_seen = 0;
  int unsigned        err_count = 0;
  int unsigned        cycles = 0;
  int unsigned        in_gap = 0;
  int unsigned        out_stall = 0;
  bit                 no_idle = 1'b0;
  spq_pkg::out_item_t want;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic spq_pkg::out_item_t apply_queue_op(spq_pkg::in_item_t op);
    spq_pkg::out_item_t r;
    int unsigned        pos;
    r = '0;
    if (op.func == spq_pkg::FUNC_PUSH) begin
      if (mirror_fill >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = mirror_fill;
        while (pos > 0 && mirror_slots[pos-1].prio > op.priority_req) begin
          mirror_slots[pos] = mirror_slots[pos-1];
          pos--;
        end
        mirror_slots[pos].prio = op.priority_req;
        mirror_slots[pos].id = mirror_next_id;
        mirror_slots[pos].payload = op.payload;
        mirror_slots[pos].stamp = mirror_next_stamp;
        r.status = spq_pkg::ST_PUSHED;
        r.entry_id = mirror_next_id;
        r.entry_stamp = mirror_next_stamp;
        mirror_next_id = mirror_next_id + 32'd1;
        mirror_next_stamp = mirror_next_stamp + 32'd1;
        mirror_fill++;
      end
    end else begin
      if (mirror_fill == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.status = spq_pkg::ST_POPPED;
        r.entry_id = mirror_slots[0].id;
        r.entry_payload = mirror_slots[0].payload;
        r.entry_priority = mirror_slots[0].prio;
        r.entry_stamp = mirror_slots[0].stamp;
        for (int k = 1; k < mirror_fill; k++) mirror_slots[k-1] = mirror_slots[k];
        mirror_fill--;
      end
    end
    r.occupancy = spq_pkg::OCC_W'(mirror_fill);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // driver and predictor
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mirror_fill = 0;
      mirror_next_id = spq_pkg::ID_START_RESET;
      mirror_next_stamp = '0;
    end else begin
      if (cfg_we) mirror_next_id = cfg_wdata;
      if (in_valid && in_ready) predicted_results.push_back(apply_queue_op(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_ops.pop_front();
          in_gap = no_idle ? 0 : gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("result item with none expected");
          err_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("entry_id", 64'(want.entry_id), 64'(out_data.entry_id));
          check_field("entry_payload", want.entry_payload, out_data.entry_payload);
          check_field("entry_priority", 64'(want.entry_priority),
                      64'(out_data.entry_priority));
          check_field("entry_stamp", 64'(want.entry_stamp), 64'(out_data.entry_stamp));
          check_field("occupancy", 64'(want.occupancy), 64'(out_data.occupancy));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) out_stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_op(logic func, logic [7:0] prio, logic [63:0] data);
    spq_pkg::in_item_t it;
    it.func = func;
    it.priority_req = prio;
    it.payload = data;
    pending_ops.push_back(it);
    ops_issued++;
  endtask

  task automatic wait_drained();
    while (results_seen != ops_issued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    logic [7:0]  dir_prio [16];
    logic [31:0] id_starts [PHASES];
    mix_t        mix;
    int unsigned push_pct;
    logic [7:0]  prio;

    dir_prio = '{8'd0, 8'd255, 8'd7, 8'd7, 8'd7, 8'd128, 8'd0, 8'd255,
                 8'd1, 8'd254, 8'd7, 8'd3, 8'd3, 8'd200, 8'd0, 8'd100};
    id_starts = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'h8000_0000,
                  $urandom(), 32'h7FFF_FFFF, 32'hFFFF_FFFE, spq_pkg::ID_START_RESET};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: pop on empty, fill with extremes and ties, refused push, partial drain
    queue_op(spq_pkg::FUNC_POP, 8'd0, '0);
    queue_op(spq_pkg::FUNC_PUSH, dir_prio[0], 64'h0);
    queue_op(spq_pkg::FUNC_PUSH, dir_prio[1], '1);
    queue_op(spq_pkg::FUNC_PUSH, dir_prio[2], 64'hAAAA_AAAA_AAAA_AAAA);
    queue_op(spq_pkg::FUNC_PUSH, dir_prio[3], 64'h5555_5555_5555_5555);
    for (int i = 4; i < 16; i++) begin
      queue_op(spq_pkg::FUNC_PUSH, dir_prio[i], {$urandom(), $urandom()});
    end
    queue_op(spq_pkg::FUNC_PUSH, 8'd42, '1);
    repeat (7) queue_op(spq_pkg::FUNC_POP, '1, '1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= id_starts[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      @(posedge clk);
      no_idle = (p == 2 || p == 5);
      for (int c = 0; c < PHASE_OPS / CHUNK_OPS; c++) begin
        mix = mix_t'($urandom_range(0, 3));
        case (mix)
          MIX_FILL:  push_pct = 85;
          MIX_DRAIN: push_pct = 15;
          default:   push_pct = 50;
        endcase
        for (int i = 0; i < CHUNK_OPS; i++) begin
          if (mix == MIX_TIES) prio = 8'($urandom_range(0, 3));
          else if ($urandom_range(0, 9) == 0) prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          else prio = 8'($urandom_range(0, 255));
          queue_op(($urandom_range(0, 99) < push_pct) ? spq_pkg::FUNC_PUSH
                                                       : spq_pkg::FUNC_POP,
                   prio, {$urandom(), $urandom()});
        end
      end
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    if (err_count == 0 && predicted_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue_core.sv
dv/tb.sv
